// File: rtl/flowc_pkg.sv
package flowc_pkg;

  // Field widths
  localparam int FLOW_BITS  = 16;
  localparam int RADIUS_W   = 15;
  localparam int WHEEL_SIZE = 55;
  localparam logic [RADIUS_W-1:0] RADIUS_RST = 15'd2560;

  // First-octant arctangent polynomial
  localparam int ATAN_C0 = 2552;
  localparam int ATAN_C1 = 692;

  // Chain lengths and stage positions
  localparam int SQ_STEPS  = 32;
  localparam int DIV_STEPS = 17;
  localparam int PH_LAT    = 4;
  localparam int ST_SQ_IN  = 2;
  localparam int ST_T      = ST_SQ_IN + DIV_STEPS;
  localparam int ST_PH     = ST_T + PH_LAT;
  localparam int ST_ROOT   = ST_SQ_IN + SQ_STEPS;
  localparam int ST_R      = ST_ROOT + DIV_STEPS;

  // Per-pixel control carried beside the arithmetic
  typedef struct packed {
    logic vld;
    logic fv;
    logic nx;
    logic ny;
    logic swap;
    logic zero;
    logic in_rng;
  } ctl_t;

  // Square-root cell state
  typedef struct packed {
    logic [33:0] rem;
    logic [31:0] root;
    logic [31:0] x;
  } sq_t;

  // Divider cell state
  typedef struct packed {
    logic [15:0] rem;
    logic [16:0] num;
    logic [15:0] d;
    logic [16:0] q;
  } dv_t;

  // Color wheel entry as {red, green, blue}
  function automatic logic [23:0] wheel_rgb(input logic [5:0] k);
    logic [23:0] c;
    unique case (k)
      6'd0:  c = {8'd255, 8'd0,   8'd0};
      6'd1:  c = {8'd255, 8'd17,  8'd0};
      6'd2:  c = {8'd255, 8'd34,  8'd0};
      6'd3:  c = {8'd255, 8'd51,  8'd0};
      6'd4:  c = {8'd255, 8'd68,  8'd0};
      6'd5:  c = {8'd255, 8'd85,  8'd0};
      6'd6:  c = {8'd255, 8'd102, 8'd0};
      6'd7:  c = {8'd255, 8'd119, 8'd0};
      6'd8:  c = {8'd255, 8'd136, 8'd0};
      6'd9:  c = {8'd255, 8'd153, 8'd0};
      6'd10: c = {8'd255, 8'd170, 8'd0};
      6'd11: c = {8'd255, 8'd187, 8'd0};
      6'd12: c = {8'd255, 8'd204, 8'd0};
      6'd13: c = {8'd255, 8'd221, 8'd0};
      6'd14: c = {8'd255, 8'd238, 8'd0};
      6'd15: c = {8'd255, 8'd255, 8'd0};
      6'd16: c = {8'd213, 8'd255, 8'd0};
      6'd17: c = {8'd170, 8'd255, 8'd0};
      6'd18: c = {8'd128, 8'd255, 8'd0};
      6'd19: c = {8'd85,  8'd255, 8'd0};
      6'd20: c = {8'd43,  8'd255, 8'd0};
      6'd21: c = {8'd0,   8'd255, 8'd0};
      6'd22: c = {8'd0,   8'd255, 8'd63};
      6'd23: c = {8'd0,   8'd255, 8'd127};
      6'd24: c = {8'd0,   8'd255, 8'd191};
      6'd25: c = {8'd0,   8'd255, 8'd255};
      6'd26: c = {8'd0,   8'd232, 8'd255};
      6'd27: c = {8'd0,   8'd209, 8'd255};
      6'd28: c = {8'd0,   8'd186, 8'd255};
      6'd29: c = {8'd0,   8'd163, 8'd255};
      6'd30: c = {8'd0,   8'd140, 8'd255};
      6'd31: c = {8'd0,   8'd116, 8'd255};
      6'd32: c = {8'd0,   8'd93,  8'd255};
      6'd33: c = {8'd0,   8'd70,  8'd255};
      6'd34: c = {8'd0,   8'd47,  8'd255};
      6'd35: c = {8'd0,   8'd24,  8'd255};
      6'd36: c = {8'd0,   8'd0,   8'd255};
      6'd37: c = {8'd19,  8'd0,   8'd255};
      6'd38: c = {8'd39,  8'd0,   8'd255};
      6'd39: c = {8'd58,  8'd0,   8'd255};
      6'd40: c = {8'd78,  8'd0,   8'd255};
      6'd41: c = {8'd98,  8'd0,   8'd255};
      6'd42: c = {8'd117, 8'd0,   8'd255};
      6'd43: c = {8'd137, 8'd0,   8'd255};
      6'd44: c = {8'd156, 8'd0,   8'd255};
      6'd45: c = {8'd176, 8'd0,   8'd255};
      6'd46: c = {8'd196, 8'd0,   8'd255};
      6'd47: c = {8'd215, 8'd0,   8'd255};
      6'd48: c = {8'd235, 8'd0,   8'd255};
      6'd49: c = {8'd255, 8'd0,   8'd255};
      6'd50: c = {8'd255, 8'd0,   8'd213};
      6'd51: c = {8'd255, 8'd0,   8'd170};
      6'd52: c = {8'd255, 8'd0,   8'd128};
      6'd53: c = {8'd255, 8'd0,   8'd85};
      6'd54: c = {8'd255, 8'd0,   8'd43};
      default: c = '0;
    endcase
    return c;
  endfunction

endpackage

// File: rtl/flowc_cfg_if.sv
interface flowc_cfg_if import flowc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [RADIUS_W-1:0] max_radius;

  modport source (output valid, output max_radius, input ready);
  modport sink (input valid, input max_radius, output ready);
endinterface

// File: rtl/flowc_flow_if.sv
interface flowc_flow_if import flowc_pkg::*; ();
  logic                        valid;
  logic                        ready;
  logic signed [FLOW_BITS-1:0] flow_x;
  logic signed [FLOW_BITS-1:0] flow_y;
  logic                        flow_valid;

  modport source (output valid, output flow_x, output flow_y, output flow_valid,
                  input ready);
  modport sink (input valid, input flow_x, input flow_y, input flow_valid,
                output ready);
endinterface

// File: rtl/flowc_pix_if.sv
interface flowc_pix_if import flowc_pkg::*; ();
  logic       valid;
  logic       ready;
  logic [7:0] blue;
  logic [7:0] green;
  logic [7:0] red;

  modport source (output valid, output blue, output green, output red, input ready);
  modport sink (input valid, input blue, input green, input red, output ready);
endinterface

// File: rtl/flowc_sqrt_cell.sv
module flowc_sqrt_cell import flowc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  sq_t  sq_i,
  output sq_t  sq_o
);

  logic [35:0] rs;
  logic [35:0] trial;
  sq_t         sq_d;
  sq_t         sq_q;

  // Bring down two radicand bits and try the next root bit
  always_comb begin
    rs    = {sq_i.rem, sq_i.x[31:30]};
    trial = {2'b00, sq_i.root, 2'b01};
    sq_d.x = {sq_i.x[29:0], 2'b00};
    if (rs >= trial) begin
      sq_d.rem  = 34'(rs - trial);
      sq_d.root = {sq_i.root[30:0], 1'b1};
    end else begin
      sq_d.rem  = rs[33:0];
      sq_d.root = {sq_i.root[30:0], 1'b0};
    end
  end

  // Hand the partial root to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sq_q <= sq_d;
    end
  end

  assign sq_o = sq_q;

endmodule

// File: rtl/flowc_div_cell.sv
module flowc_div_cell import flowc_pkg::*; (
  input  logic clk_i,
  input  logic en_i,
  input  dv_t  dv_i,
  output dv_t  dv_o
);

  logic [16:0] rs;
  dv_t         dv_d;
  dv_t         dv_q;

  // Shift in one numerator bit and resolve one quotient bit
  always_comb begin
    rs     = {dv_i.rem, dv_i.num[16]};
    dv_d.d = dv_i.d;
    dv_d.num = {dv_i.num[15:0], 1'b0};
    if (rs >= {1'b0, dv_i.d}) begin
      dv_d.rem = 16'(rs - {1'b0, dv_i.d});
      dv_d.q   = {dv_i.q[15:0], 1'b1};
    end else begin
      dv_d.rem = rs[15:0];
      dv_d.q   = {dv_i.q[15:0], 1'b0};
    end
  end

  // Hand the partial quotient to the next cell
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dv_q <= dv_d;
    end
  end

  assign dv_o = dv_q;

endmodule

// File: rtl/flowc_phase.sv
module flowc_phase import flowc_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [16:0] t_i,
  input  ctl_t        ctl_i,
  output logic [15:0] phase_o
);

  logic [16:0] omt;
  logic [33:0] tt_prod;
  logic [26:0] tc_prod;
  logic [16:0] t_a_q;
  logic [14:0] u_a_q;
  logic [11:0] v_a_q;
  ctl_t        ctl_a_q;
  logic [16:0] t_b_q;
  logic [26:0] uv_b_q;
  ctl_t        ctl_b_q;
  logic [30:0] oct_sum;
  logic [13:0] oct_c_q;
  ctl_t        ctl_c_q;
  logic [14:0] phi;
  logic [16:0] phase_full;
  logic [15:0] phase_q;

  // Products for the quadratic correction term
  assign omt     = 17'h10000 - t_i;
  assign tt_prod = 34'(t_i) * 34'(omt);
  assign tc_prod = 27'(t_i) * 27'(ATAN_C1);

  // Stage a: u and v
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_a_q   <= t_i;
      u_a_q   <= tt_prod[30:16];
      v_a_q   <= 12'(ATAN_C0) + 12'(tc_prod[26:16]);
      ctl_a_q <= ctl_i;
    end
  end

  // Stage b: u times v
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t_b_q   <= t_a_q;
      uv_b_q  <= 27'(u_a_q) * 27'(v_a_q);
      ctl_b_q <= ctl_a_q;
    end
  end

  // Stage c: first-octant angle
  assign oct_sum = {1'b0, t_b_q, 13'b0} + 31'(uv_b_q) + 31'd32768;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      oct_c_q <= oct_sum[29:16];
      ctl_c_q <= ctl_b_q;
    end
  end

  // Stage d: mirror into octant and quadrant
  always_comb begin
    if (ctl_c_q.zero) begin
      phi = '0;
    end else if (ctl_c_q.swap) begin
      phi = 15'd16384 - 15'(oct_c_q);
    end else begin
      phi = 15'(oct_c_q);
    end
    if (!ctl_c_q.nx && !ctl_c_q.ny) begin
      phase_full = 17'(phi);
    end else if (ctl_c_q.nx && !ctl_c_q.ny) begin
      phase_full = 17'd32768 - 17'(phi);
    end else if (ctl_c_q.nx && ctl_c_q.ny) begin
      phase_full = 17'd32768 + 17'(phi);
    end else begin
      phase_full = 17'h10000 - 17'(phi);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      phase_q <= phase_full[15:0];
    end
  end

  assign phase_o = phase_q;

endmodule

// File: rtl/flowc_blend.sv
module flowc_blend import flowc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        en_i,
  input  ctl_t        ctl_i,
  input  logic [15:0] phase_i,
  input  logic [16:0] r_i,
  output logic        valid_o,
  output logic [23:0] rgb_o
);

  logic [21:0] w;
  logic [5:0]  k0;
  logic [5:0]  k1;
  ctl_t        ctl_a_q, ctl_b_q, ctl_c_q, ctl_d_q;
  logic [16:0] r_a_q, r_b_q, r_c_q;
  logic [5:0]  k0_a_q, k1_a_q;
  logic [15:0] f_a_q, f_b_q;
  logic [23:0] c0_b_q, c1_b_q;
  logic [16:0] fc;
  logic [23:0] bl [3];
  logic [23:0] bl_c_q [3];
  logic [40:0] p_d_q [3];
  logic [7:0]  o_d_q [3];
  logic [39:0] diff [3];
  logic [23:0] rgb_d;
  logic        vld_q;
  logic [23:0] rgb_q;

  // Stage a: wheel position
  assign w  = 22'(phase_i) * 22'(WHEEL_SIZE - 1);
  assign k0 = w[21:16];
  assign k1 = (k0 == 6'(WHEEL_SIZE - 1)) ? 6'd0 : 6'(k0 + 6'd1);

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      k0_a_q <= k0;
      k1_a_q <= k1;
      f_a_q  <= w[15:0];
      r_a_q  <= r_i;
    end
  end

  // Stage b: look up both wheel entries
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c0_b_q <= wheel_rgb(k0_a_q);
      c1_b_q <= wheel_rgb(k1_a_q);
      f_b_q  <= f_a_q;
      r_b_q  <= r_a_q;
    end
  end

  // Stage c: linear blend per channel
  assign fc = 17'h10000 - {1'b0, f_b_q};

  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      bl[ch] = 24'(25'(fc) * 25'(c0_b_q[8*ch +: 8]))
             + 24'(25'(f_b_q) * 25'(c1_b_q[8*ch +: 8]));
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      bl_c_q <= bl;
      r_c_q  <= r_b_q;
    end
  end

  // Stage d: saturation product and dimmed value
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int ch = 0; ch < 3; ch++) begin
        p_d_q[ch] <= 41'(r_c_q) * 41'(24'(255 * 65536) - bl_c_q[ch]);
        o_d_q[ch] <= 8'((26'(bl_c_q[ch]) * 26'd3) >> 18);
      end
    end
  end

  // Stage e: pick the result and register the pixel
  always_comb begin
    for (int ch = 0; ch < 3; ch++) begin
      diff[ch] = {8'd255, 32'd0} - p_d_q[ch][39:0];
      if (!ctl_d_q.fv) begin
        rgb_d[8*ch +: 8] = '0;
      end else if (ctl_d_q.in_rng) begin
        rgb_d[8*ch +: 8] = diff[ch][39:32];
      end else begin
        rgb_d[8*ch +: 8] = o_d_q[ch];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rgb_q <= rgb_d;
    end
  end

  // Advance control through the stages
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl_a_q <= '0;
      ctl_b_q <= '0;
      ctl_c_q <= '0;
      ctl_d_q <= '0;
      vld_q   <= 1'b0;
    end else if (en_i) begin
      ctl_a_q <= ctl_i;
      ctl_b_q <= ctl_a_q;
      ctl_c_q <= ctl_b_q;
      ctl_d_q <= ctl_c_q;
      vld_q   <= ctl_d_q.vld;
    end
  end

  assign valid_o = vld_q;
  assign rgb_o   = rgb_q;

endmodule

// File: rtl/flow_color_wheel_coder.sv
// A pixel passes through the capture stages, 32 square-root cells, 17 divider
// cells and 5 blend stages, and is held in place while the output is stalled.
// Throughput: one pixel per cycle; the whole pipeline holds while an output waits.
// Reset clears all valid bits and sets max_radius to 2560 (10.0 pixels).
module flow_color_wheel_coder import flowc_pkg::*; (
  input  logic         clk_i,
  input  logic         rst_ni,
  flowc_cfg_if.sink    cfg,
  flowc_flow_if.sink   flow,
  flowc_pix_if.source  pix
);

  logic                  en;
  logic [RADIUS_W-1:0]   radius_q;
  logic [RADIUS_W-1:0]   m_eff;
  logic [2*RADIUS_W-1:0] msq_q;
  ctl_t                  ctl_q [ST_R+1];
  ctl_t                  ctl_d0;
  ctl_t                  ctl_d1;
  ctl_t                  ctl_d2;
  logic [15:0]           ax_q, ay_q;
  logic [31:0]           sqx_q, sqy_q;
  logic [15:0]           mn1_q, mx1_q;
  logic [31:0]           s_q;
  logic [31:0]           s_sum;
  logic [15:0]           mn2_q, mx2_q;
  sq_t                   sq_w [SQ_STEPS+1];
  dv_t                   td_w [DIV_STEPS+1];
  dv_t                   rd_w [DIV_STEPS+1];
  logic [15:0]           phase_w;
  logic [15:0]           ph_q [ST_PH+1:ST_R];
  logic                  out_vld;
  logic [23:0]           rgb;

  // Hold the pipeline while a finished pixel waits
  assign en         = !out_vld || pix.ready;
  assign flow.ready = en;
  assign cfg.ready  = 1'b1;

  // Radius register and its square
  assign m_eff = (radius_q == '0) ? RADIUS_W'(1) : radius_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      radius_q <= RADIUS_RST;
      msq_q    <= (2*RADIUS_W)'(RADIUS_RST) * (2*RADIUS_W)'(RADIUS_RST);
    end else begin
      if (cfg.valid) begin
        radius_q <= cfg.max_radius;
      end
      msq_q <= (2*RADIUS_W)'(m_eff) * (2*RADIUS_W)'(m_eff);
    end
  end

  // Stage 0: capture the transaction as signs and magnitudes
  always_comb begin
    ctl_d0        = '0;
    ctl_d0.vld    = flow.valid;
    ctl_d0.fv     = flow.flow_valid;
    ctl_d0.nx     = flow.flow_x[FLOW_BITS-1];
    ctl_d0.ny     = flow.flow_y[FLOW_BITS-1];
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      ax_q  <= flow.flow_x[FLOW_BITS-1] ? 16'(-flow.flow_x) : 16'(flow.flow_x);
      ay_q  <= flow.flow_y[FLOW_BITS-1] ? 16'(-flow.flow_y) : 16'(flow.flow_y);
      sqx_q <= 32'(ax_q) * 32'(ax_q);
      sqy_q <= 32'(ay_q) * 32'(ay_q);
      mn1_q <= (ay_q > ax_q) ? ax_q : ay_q;
      mx1_q <= (ay_q > ax_q) ? ay_q : ax_q;
      s_q   <= s_sum;
      mn2_q <= mn1_q;
      mx2_q <= mx1_q;
    end
  end

  assign s_sum = sqx_q + sqy_q;

  // Add octant flags at stage 1 and the range flag at stage 2
  always_comb begin
    ctl_d1        = ctl_q[0];
    ctl_d1.swap   = ay_q > ax_q;
    ctl_d1.zero   = (ax_q == '0) && (ay_q == '0);
    ctl_d2        = ctl_q[1];
    ctl_d2.in_rng = s_sum <= 32'(msq_q);
  end

  // Control pipeline beside the cell chains
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i <= ST_R; i++) begin
        ctl_q[i] <= '0;
      end
    end else if (en) begin
      ctl_q[0] <= ctl_d0;
      ctl_q[1] <= ctl_d1;
      ctl_q[2] <= ctl_d2;
      for (int i = 3; i <= ST_R; i++) begin
        ctl_q[i] <= ctl_q[i-1];
      end
    end
  end

  // Square-root chain on the squared magnitude
  assign sq_w[0] = '{rem: '0, root: '0, x: s_q};

  for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
    flowc_sqrt_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .sq_i  (sq_w[k]),
      .sq_o  (sq_w[k+1])
    );
  end

  // Ratio chain: min over max in Q16
  assign td_w[0] = '{rem: {1'b0, mn2_q[15:1]}, num: {mn2_q[0], 16'b0}, d: mx2_q, q: '0};

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_td
    flowc_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .dv_i  (td_w[j]),
      .dv_o  (td_w[j+1])
    );
  end

  // Angle from the ratio
  flowc_phase u_phase (
    .clk_i   (clk_i),
    .en_i    (en),
    .t_i     (td_w[DIV_STEPS].q),
    .ctl_i   (ctl_q[ST_T]),
    .phase_o (phase_w)
  );

  // Delay the phase until the radius is ready
  always_ff @(posedge clk_i) begin
    if (en) begin
      ph_q[ST_PH+1] <= phase_w;
      for (int i = ST_PH + 2; i <= ST_R; i++) begin
        ph_q[i] <= ph_q[i-1];
      end
    end
  end

  // Radius chain: root over max_radius
  assign rd_w[0] = '{rem: {1'b0, sq_w[SQ_STEPS].root[31:17]},
                     num: sq_w[SQ_STEPS].root[16:0],
                     d: {1'b0, m_eff}, q: '0};

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_rd
    flowc_div_cell u_cell (
      .clk_i (clk_i),
      .en_i  (en),
      .dv_i  (rd_w[j]),
      .dv_o  (rd_w[j+1])
    );
  end

  // Wheel blend and output register
  flowc_blend u_blend (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .ctl_i   (ctl_q[ST_R]),
    .phase_i (ph_q[ST_R]),
    .r_i     (rd_w[DIV_STEPS].q),
    .valid_o (out_vld),
    .rgb_o   (rgb)
  );

  assign pix.valid = out_vld;
  assign pix.red   = rgb[23:16];
  assign pix.green = rgb[15:8];
  assign pix.blue  = rgb[7:0];

endmodule

// File: rtl/flowc_checker.sv
module flowc_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_valid_i,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic        cfg_ready_i,
  input logic [23:0] out_rgb_i
);

  // Stalled pixel holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_rgb_i))
    else $error("stalled pixel changed");

  // Output drops only after a transaction
  a_out_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(out_valid_i) |-> $past(out_ready_i))
    else $error("pixel dropped without transaction");

  // Input side is open whenever the output is not stalled
  a_in_open: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(out_valid_i && !out_ready_i) |-> in_ready_i)
    else $error("input blocked without output stall");

  // No input is taken during an output stall
  a_in_block: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |-> !in_ready_i || !in_valid_i || in_ready_i == cfg_ready_i
      && !in_ready_i)
    else $error("input taken during output stall");

  // Configuration is always taken
  a_cfg_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_ready_i)
    else $error("configuration not ready");

endmodule

bind flow_color_wheel_coder flowc_checker u_flowc_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (flow.valid),
  .in_ready_i  (flow.ready),
  .out_valid_i (pix.valid),
  .out_ready_i (pix.ready),
  .cfg_ready_i (cfg.ready),
  .out_rgb_i   ({pix.red, pix.green, pix.blue})
);
